/* src/point_cloud_height_map_macros.svh */
// Assertion macros shared by the height map design files.
`ifndef POINT_CLOUD_HEIGHT_MAP_MACROS_SVH
`define POINT_CLOUD_HEIGHT_MAP_MACROS_SVH

// Checks that the consequence holds in the same cycle as the antecedent.
`define PCHM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequence holds in the cycle after the antecedent.
`define PCHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pchm_pkg.sv */
// Shared widths, types and register indexes of the height map block.
package pchm_pkg;

    // Field widths fixed by the interface.
    localparam int COORD_W   = 16;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 9;
    localparam int CODE_W    = 8;
    localparam int CODE_TOP  = 255;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_LOW_X  = 3'd0;
    localparam cfg_idx_t REG_HIGH_X = 3'd1;
    localparam cfg_idx_t REG_LOW_Y  = 3'd2;
    localparam cfg_idx_t REG_HIGH_Y = 3'd3;
    localparam cfg_idx_t REG_LOW_Z  = 3'd4;
    localparam cfg_idx_t REG_HIGH_Z = 3'd5;

endpackage

/* src/point_cloud_height_map.sv */
// Top level of the point cloud max-height map block.
//
// Input channel (s_*): one request per point insert (s_action = 0) or cell
// read (s_action = 1). An insert inside the open box set by the six bound
// registers is scaled into a map cell and a height code, and the cell keeps
// the larger code. A read returns the stored code of one cell and clears it.
// Result channel (m_*): exactly one result per request, in request order.
// Configuration (cfg_*): always ready; write only while the block is idle.
// Requests are handled one at a time. An insert inside the box passes through
// the check state, the bit-serial scaling units, the address, read and update
// states of the read-modify-write of the map memory and the emit state; a read
// in the map skips the scaling, and a point outside the box or a read beyond
// the map goes from the check state straight to emit. The block is ready for
// the next request in the cycle after a result is loaded. The previous result
// may still wait in the output register meanwhile, so a stalled receiver costs
// nothing until a second result is ready.
// After reset a clearing pass writes zero to every map cell, one per cycle,
// during which s_ready stays low.
`include "point_cloud_height_map_macros.svh"

module point_cloud_height_map import pchm_pkg::*; #(
    parameter int MAP_WIDTH  = 640,
    parameter int MAP_HEIGHT = 480
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  coord_t              s_point_x,
    input  coord_t              s_point_y,
    input  coord_t              s_point_z,
    input  logic [COL_W-1:0]    s_read_col,
    input  logic [ROW_W-1:0]    s_read_row,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_inside_res,
    output logic [COL_W-1:0]    m_cell_col,
    output logic [ROW_W-1:0]    m_cell_row,
    output logic [CODE_W-1:0]   m_height_code,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_idx_t            cfg_index,
    input  logic [COORD_W-1:0]  cfg_data
);

    localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAP_WIDTH);
    localparam int RW    = $clog2(MAP_HEIGHT);
    localparam int ZW    = $clog2(CODE_TOP + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCALE,
        ST_ADDR,
        ST_READ,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Bound registers.
    coord_t low_x_reg, high_x_reg, low_y_reg, high_y_reg, low_z_reg, high_z_reg;

    state_t              state_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic                action_reg;
    coord_t              pt_x_reg, pt_y_reg, pt_z_reg;
    logic [COL_W-1:0]    rd_col_reg;
    logic [ROW_W-1:0]    rd_row_reg;
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic [AW-1:0]       addr_reg;
    logic                res_inside_reg;
    logic [COL_W-1:0]    res_col_reg;
    logic [ROW_W-1:0]    res_row_reg;
    logic [CODE_W-1:0]   res_code_reg;

    logic                m_valid_reg;
    logic                m_inside_res_reg;
    logic [COL_W-1:0]    m_cell_col_reg;
    logic [ROW_W-1:0]    m_cell_row_reg;
    logic [CODE_W-1:0]   m_height_code_reg;

    logic                in_box;
    logic                in_range;
    logic [COORD_W-1:0]  num_x, num_y, num_z, den_x, den_y, den_z;
    logic                scale_start;
    logic                busy_x, busy_y, busy_z, any_busy;
    logic [CW-1:0]       quot_x;
    logic [RW-1:0]       quot_y;
    logic [ZW-1:0]       quot_z;
    logic [RW-1:0]       row_calc;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [CODE_W-1:0]   ram_wr_data;
    logic [CODE_W-1:0]   ram_rd_data;
    logic                out_load;
    logic                wr_phase;

    // Configuration writes; indexes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_x_reg  <= 16'sd0;
            high_x_reg <= 16'sd10000;
            low_y_reg  <= -16'sd3000;
            high_y_reg <= 16'sd3000;
            low_z_reg  <= 16'sd0;
            high_z_reg <= 16'sd2500;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LOW_X:  low_x_reg  <= cfg_data;
                REG_HIGH_X: high_x_reg <= cfg_data;
                REG_LOW_Y:  low_y_reg  <= cfg_data;
                REG_HIGH_Y: high_y_reg <= cfg_data;
                REG_LOW_Z:  low_z_reg  <= cfg_data;
                REG_HIGH_Z: high_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Open-box test on the captured point and map range test for reads.
    assign in_box = (pt_z_reg < high_z_reg) && (pt_z_reg > low_z_reg) &&
                    (pt_x_reg > low_x_reg)  && (pt_x_reg < high_x_reg) &&
                    (pt_y_reg > low_y_reg)  && (pt_y_reg < high_y_reg);
    assign in_range = (32'(rd_col_reg) < 32'(MAP_WIDTH)) &&
                      (32'(rd_row_reg) < 32'(MAP_HEIGHT));

    // Offsets and spans; both are positive and fit 16 bits for a point inside.
    assign num_x = pt_x_reg - low_x_reg;
    assign num_y = pt_y_reg - low_y_reg;
    assign num_z = pt_z_reg - low_z_reg;
    assign den_x = high_x_reg - low_x_reg;
    assign den_y = high_y_reg - low_y_reg;
    assign den_z = high_z_reg - low_z_reg;

    assign scale_start = (state_reg == ST_CHECK) && !action_reg && in_box;
    assign any_busy    = busy_x || busy_y || busy_z;

    // One scaling unit per axis, all started together.
    pchm_scale #(.TOP(MAP_WIDTH - 1)) u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .num     (num_x),
        .den     (den_x),
        .busy    (busy_x),
        .quot    (quot_x)
    );

    pchm_scale #(.TOP(MAP_HEIGHT - 1)) u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .num     (num_y),
        .den     (den_y),
        .busy    (busy_y),
        .quot    (quot_y)
    );

    pchm_scale #(.TOP(CODE_TOP)) u_scale_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .num     (num_z),
        .den     (den_z),
        .busy    (busy_z),
        .quot    (quot_z)
    );

    // Rows count down from the far edge of the map.
    assign row_calc = RW'(MAP_HEIGHT - 1) - quot_y;

    // Map memory: the clearing pass writes zeros, otherwise the update state
    // writes back the new maximum or the cleared cell.
    assign ram_wr_en   = (state_reg == ST_CLEAR) ||
                         ((state_reg == ST_UPDATE) &&
                          (action_reg || (res_code_reg > ram_rd_data)));
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wr_data = ((state_reg == ST_CLEAR) || action_reg) ? '0 : res_code_reg;
    assign wr_phase    = (state_reg == ST_CLEAR) || (state_reg == ST_UPDATE);

    pchm_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // Request sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        action_reg <= s_action;
                        pt_x_reg   <= s_point_x;
                        pt_y_reg   <= s_point_y;
                        pt_z_reg   <= s_point_z;
                        rd_col_reg <= s_read_col;
                        rd_row_reg <= s_read_row;
                        state_reg  <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (action_reg) begin
                        res_inside_reg <= 1'b1;
                        res_col_reg    <= rd_col_reg;
                        res_row_reg    <= rd_row_reg;
                        res_code_reg   <= '0;
                        col_reg        <= CW'(rd_col_reg);
                        row_reg        <= RW'(rd_row_reg);
                        state_reg      <= in_range ? ST_ADDR : ST_EMIT;
                    end else if (in_box) begin
                        res_inside_reg <= 1'b1;
                        state_reg      <= ST_SCALE;
                    end else begin
                        res_inside_reg <= 1'b0;
                        res_col_reg    <= '0;
                        res_row_reg    <= '0;
                        res_code_reg   <= '0;
                        state_reg      <= ST_EMIT;
                    end
                end
                ST_SCALE: begin
                    if (!any_busy) begin
                        col_reg      <= quot_x;
                        row_reg      <= row_calc;
                        res_col_reg  <= COL_W'(quot_x);
                        res_row_reg  <= ROW_W'(row_calc);
                        res_code_reg <= CODE_W'(quot_z);
                        state_reg    <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    addr_reg  <= AW'(AW'(row_reg) * AW'(MAP_WIDTH) + AW'(col_reg));
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE: begin
                    if (action_reg) begin
                        res_code_reg <= ram_rd_data;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_load) begin
                        m_inside_res_reg  <= res_inside_reg;
                        m_cell_col_reg    <= res_col_reg;
                        m_cell_row_reg    <= res_row_reg;
                        m_height_code_reg <= res_code_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_inside_res  = m_inside_res_reg;
    assign m_cell_col    = m_cell_col_reg;
    assign m_cell_row    = m_cell_row_reg;
    assign m_height_code = m_height_code_reg;

    // Design checks.
    `PCHM_ASSERT_NOW(a_map_write_phase, ram_wr_en, wr_phase, "map written outside clear or update")
    `PCHM_ASSERT_NEXT(a_accept, s_valid && s_ready, state_reg == ST_CHECK, "no check after accept")
    `PCHM_ASSERT_NOW(a_load_when_free, out_load, !m_valid_reg || m_ready, "result overwritten")
    `PCHM_ASSERT_NOW(a_scale_done, state_reg == ST_ADDR, !any_busy, "scaling still busy")

endmodule

/* src/pchm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pchm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/pchm_scale.sv */
// Scaling unit: floor(num * TOP / den) for num < den, one quotient bit per cycle.
module pchm_scale import pchm_pkg::*; #(
    parameter int TOP = 255
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [COORD_W-1:0]          num,
    input  logic [COORD_W-1:0]          den,
    output logic                        busy,
    output logic [$clog2(TOP + 1)-1:0]  quot
);

    localparam int QW    = $clog2(TOP + 1);
    localparam int PW    = COORD_W + QW;
    localparam int CNT_W = $clog2(QW + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } state_t;

    state_t             state_reg;
    logic [COORD_W-1:0] num_reg;
    logic [COORD_W-1:0] den_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [QW-1:0]      nlow_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [PW-1:0]      prod;
    logic [COORD_W:0]   trial;
    logic [COORD_W:0]   diff;
    logic               ge;

    // Product of the operand and the scale; it is below den * 2^QW, so its
    // upper part starts out smaller than the divisor.
    assign prod = PW'(num_reg) * PW'(TOP);

    // Restoring division step: bring down the next bit and try a subtract.
    assign trial = {rem_reg, nlow_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    assign busy = (state_reg != ST_IDLE);
    assign quot = nlow_reg;

    // Sequencer: load, multiply, then QW division steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        num_reg   <= num;
                        den_reg   <= den;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    rem_reg   <= prod[PW-1:QW];
                    nlow_reg  <= prod[QW-1:0];
                    cnt_reg   <= CNT_W'(QW);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                    nlow_reg <= QW'({nlow_reg, ge});
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the point cloud max-height map block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pchm_pkg::*;

    localparam int MAP_W        = 640;
    localparam int MAP_H        = 480;
    localparam int NUM_PHASES   = 8;
    localparam int RANDOM_ITEMS = 225;
    localparam int DRAIN_CYCLES = 32;
    // The limit covers the clearing pass of every map cell and about 2000
    // requests at their slowest pacing, with a wide margin.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int MAX_REPORTS  = 50;

    // Request kinds carried on s_action.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Register indexes past the end of the list; the block ignores them.
    localparam cfg_idx_t REG_SPARE_A = 3'd6;
    localparam cfg_idx_t REG_SPARE_B = 3'd7;

    typedef struct {
        logic              action;
        coord_t            point_x;
        coord_t            point_y;
        coord_t            point_z;
        logic [COL_W-1:0]  read_col;
        logic [ROW_W-1:0]  read_row;
    } request_t;

    typedef struct {
        logic              in_box;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CODE_W-1:0] code;
    } map_result_t;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cell_pos_t;

    // Tracks the height map and the box, and checks results in order.
    class height_map_scoreboard;
        bit [CODE_W-1:0] cells[];
        int              lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
        map_result_t     awaited_q[$];
        cell_pos_t       touched[$];
        int              errors;
        int              n_inside, n_outside, n_reads, n_off_map, n_nonzero;

        function new();
            cells = new[MAP_W * MAP_H];
            lo_x = 0;
            hi_x = 10000;
            lo_y = -3000;
            hi_y = 3000;
            lo_z = 0;
            hi_z = 2500;
        endfunction

        function void write_register(cfg_idx_t idx, logic [COORD_W-1:0] data);
            int v;
            v = int'($signed(data));
            case (idx)
                REG_LOW_X:  lo_x = v;
                REG_HIGH_X: hi_x = v;
                REG_LOW_Y:  lo_y = v;
                REG_HIGH_Y: hi_y = v;
                REG_LOW_Z:  lo_z = v;
                REG_HIGH_Z: hi_z = v;
                default: ;
            endcase
        endfunction

        // Floor of top * (v - lo) / (hi - lo); only called with lo < v < hi.
        function int scale_down(int v, int lo, int hi, int top);
            return ((v - lo) * top) / (hi - lo);
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // Applies one accepted request to the map and queues its result.
        function void note_request(request_t r);
            map_result_t res;
            cell_pos_t   pos;
            int          x, y, z, idx;
            res = '{1'b0, '0, '0, '0};
            if (r.action == ACT_READ) begin
                res.in_box = 1'b1;
                res.col    = r.read_col;
                res.row    = r.read_row;
                n_reads++;
                if (r.read_col < MAP_W && r.read_row < MAP_H) begin
                    idx        = int'(r.read_row) * MAP_W + int'(r.read_col);
                    res.code   = cells[idx];
                    cells[idx] = '0;
                    if (res.code != 0) n_nonzero++;
                end else begin
                    n_off_map++;
                end
            end else begin
                x = int'(r.point_x);
                y = int'(r.point_y);
                z = int'(r.point_z);
                if (x > lo_x && x < hi_x && y > lo_y && y < hi_y &&
                    z > lo_z && z < hi_z) begin
                    res.in_box = 1'b1;
                    res.col  = COL_W'(scale_down(x, lo_x, hi_x, MAP_W - 1));
                    res.row  = ROW_W'((MAP_H - 1) - scale_down(y, lo_y, hi_y, MAP_H - 1));
                    res.code = CODE_W'(scale_down(z, lo_z, hi_z, CODE_TOP));
                    idx = int'(res.row) * MAP_W + int'(res.col);
                    if (res.code > cells[idx]) cells[idx] = res.code;
                    pos.col = res.col;
                    pos.row = res.row;
                    touched = {touched, pos};
                    if (touched.size() > 64) void'(touched.pop_front());
                    n_inside++;
                end else begin
                    n_outside++;
                end
            end
            awaited_q = {awaited_q, res};
        endfunction

        function void report(string what, int want, int got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s differs, expected %0d, actual %0d",
                         $time, what, want, got);
        endfunction

        // Compares one accepted result with the oldest pending one.
        function void check_result(map_result_t got);
            map_result_t want;
            if (awaited_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                         $time, got.in_box, got.col, got.row, got.code);
                return;
            end
            want = awaited_q.pop_front();
            if (got.in_box !== want.in_box) report("inside_res", want.in_box, got.in_box);
            if (got.col !== want.col)       report("cell_col", want.col, got.col);
            if (got.row !== want.row)       report("cell_row", want.row, got.row);
            if (got.code !== want.code)     report("height_code", want.code, got.code);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_action      = ACT_INSERT;
    coord_t              s_point_x     = '0;
    coord_t              s_point_y     = '0;
    coord_t              s_point_z     = '0;
    logic [COL_W-1:0]    s_read_col    = '0;
    logic [ROW_W-1:0]    s_read_row    = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_inside_res;
    logic [COL_W-1:0]    m_cell_col;
    logic [ROW_W-1:0]    m_cell_row;
    logic [CODE_W-1:0]   m_height_code;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    cfg_idx_t            cfg_index     = REG_LOW_X;
    logic [COORD_W-1:0]  cfg_data      = '0;

    int                  send_gap_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  cycle_count   = 0;
    height_map_scoreboard sb = new();

    point_cloud_height_map #(
        .MAP_WIDTH  (MAP_W),
        .MAP_HEIGHT (MAP_H)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_z     (s_point_z),
        .s_read_col    (s_read_col),
        .s_read_row    (s_read_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_cell_col    (m_cell_col),
        .m_cell_row    (m_cell_row),
        .m_height_code (m_height_code),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_inside_res, m_cell_col, m_cell_row, m_height_code});
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped at cycle limit with %0d results pending", sb.pending());
            $display("point_cloud_height_map: mismatch");
            $finish;
        end
    end

    function automatic request_t make_insert(int x, int y, int z);
        request_t r;
        r.action   = ACT_INSERT;
        r.point_x  = coord_t'(x);
        r.point_y  = coord_t'(y);
        r.point_z  = coord_t'(z);
        r.read_col = COL_W'($urandom);
        r.read_row = ROW_W'($urandom);
        return r;
    endfunction

    function automatic request_t make_read(int col, int row);
        request_t r;
        r.action   = ACT_READ;
        r.point_x  = coord_t'($urandom);
        r.point_y  = coord_t'($urandom);
        r.point_z  = coord_t'($urandom);
        r.read_col = COL_W'(col);
        r.read_row = ROW_W'(row);
        return r;
    endfunction

    // Mostly inside the open interval, with bounds, neighbors and noise.
    function automatic int pick_coord(int lo, int hi);
        int roll;
        roll = $urandom_range(99);
        if (hi - lo >= 2) begin
            if (roll < 82) return lo + int'($urandom_range(hi - lo - 1, 1));
            if (roll < 88) return (roll % 2) ? lo + 1 : hi - 1;
        end
        if (roll < 94) return (roll % 2) ? lo : hi;
        if (roll < 96) return (roll % 2) ? -32768 : 32767;
        return int'(coord_t'($urandom));
    endfunction

    function automatic request_t random_request();
        request_t  r;
        cell_pos_t pos;
        int        roll;
        if ($urandom_range(99) >= 25)
            return make_insert(pick_coord(sb.lo_x, sb.hi_x), pick_coord(sb.lo_y, sb.hi_y),
                               pick_coord(sb.lo_z, sb.hi_z));
        roll = $urandom_range(99);
        if (roll < 70 && sb.touched.size() > 0) begin
            pos = sb.touched[$urandom_range(sb.touched.size() - 1)];
            r = make_read(pos.col, pos.row);
        end else if (roll < 90) begin
            r = make_read($urandom_range(MAP_W - 1), $urandom_range(MAP_H - 1));
        end else if (roll % 2) begin
            r = make_read($urandom_range(2**COL_W - 1, MAP_W), $urandom_range(2**ROW_W - 1));
        end else begin
            r = make_read($urandom_range(2**COL_W - 1), $urandom_range(2**ROW_W - 1, MAP_H));
        end
        return r;
    endfunction

    // Drives one request and waits for its handshake.
    task automatic push_request(request_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= r.action;
        s_point_x  <= r.point_x;
        s_point_y  <= r.point_y;
        s_point_z  <= r.point_z;
        s_read_col <= r.read_col;
        s_read_row <= r.read_row;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(r);
    endtask

    // Holds the sender off until every result is back and the block is quiet.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= COORD_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, COORD_W'(value));
    endtask

    task automatic apply_box(int lx, int hx, int ly, int hy, int lz, int hz);
        write_reg(REG_LOW_X, lx);
        write_reg(REG_HIGH_X, hx);
        write_reg(REG_LOW_Y, ly);
        write_reg(REG_HIGH_Y, hy);
        write_reg(REG_LOW_Z, lz);
        write_reg(REG_HIGH_Z, hz);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void random_span(output int lo, output int hi);
        int a, b;
        a  = int'(coord_t'($urandom));
        b  = int'(coord_t'($urandom));
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
    endfunction

    initial begin
        request_t directed_q[$];
        int       lx, hx, ly, hy, lz, hz;

        // Reset, then wait out the clearing pass.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!s_ready);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 75; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 75; end
                default: begin send_gap_pct = 34; recv_stall_pct = 34; end
            endcase

            // Box for this phase; the first phase runs on the reset values.
            case (phase)
                1: apply_box(-32768, 32767, -32768, 32767, -32768, 32767);
                2: apply_box(-4, 4, -3, 3, 0, 3);
                3: begin
                    write_reg(REG_SPARE_A, int'(coord_t'($urandom)));
                    write_reg(REG_SPARE_B, int'(coord_t'($urandom)));
                    apply_box(100, 100, 50, -50, 10, -10);
                end
                6: apply_box(-1, 1, 32765, 32767, -32768, 32767);
                4, 5, 7: begin
                    random_span(lx, hx);
                    random_span(ly, hy);
                    random_span(lz, hz);
                    apply_box(lx, hx, ly, hy, lz, hz);
                end
                default: ;
            endcase

            // Corner cells, bounds, extremes, max-keeping and clear-on-read.
            if (phase == 0) begin
                directed_q = '{
                    make_insert(1, -2999, 1),        make_insert(9999, 2999, 2499),
                    make_insert(0, 0, 100),          make_insert(10000, 0, 100),
                    make_insert(5000, -3000, 100),   make_insert(5000, 3000, 100),
                    make_insert(5000, 0, 0),         make_insert(5000, 0, 2500),
                    make_insert(-32768, -32768, -32768),
                    make_insert(32767, 32767, 32767),
                    make_insert(5000, 0, 1250),      make_insert(5000, 0, 2000),
                    make_insert(5000, 0, 100),
                    make_read(319, 240),             make_read(319, 240),
                    make_read(0, 479),               make_read(638, 1),
                    make_read(640, 0),               make_read(1023, 511),
                    make_read(0, 480),               make_read(639, 479),
                    make_read(0, 0)
                };
                foreach (directed_q[i]) push_request(directed_q[i]);
            end

            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                // Let the pipeline run dry once in the middle of a phase.
                if (phase == 2 && n == RANDOM_ITEMS / 2) settle();
                push_request(random_request());
            end
            settle();
        end

        $display("Ran %0d inserts (%0d in the box) and %0d reads (%0d nonzero, %0d off the map)",
                 sb.n_inside + sb.n_outside, sb.n_inside,
                 sb.n_reads, sb.n_nonzero, sb.n_off_map);
        $display("over %0d box settings, empty and full-range ones among them, in four pacings",
                 NUM_PHASES);
        if (sb.errors == 0) begin
            $display("point_cloud_height_map: match");
        end else begin
            $display("point_cloud_height_map: mismatch");
        end
        $finish;
    end

endmodule
